### hdl/spfa_shortest_paths_defines.svh
// Assertion macros shared by the SPFA shortest paths design.
`ifndef SPFA_SHORTEST_PATHS_DEFINES_SVH
`define SPFA_SHORTEST_PATHS_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define SPFA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define SPFA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

### hdl/spfa_pkg.sv
// Package with the shared constants and types of the SPFA shortest paths block.
`default_nettype none
package spfa_pkg;
  localparam int MaxNodes   = 64;
  localparam int MaxEdges   = 1024;
  localparam int NodeBits   = 6;
  localparam int EdgeBits   = 10;
  localparam int LinkBits   = 11;
  localparam int WeightBits = 16;
  localparam int DistBits   = 32;
  localparam int CountBits  = 7;
  localparam logic [DistBits-1:0] InfDist = 32'd1000000000;
  localparam logic [LinkBits-1:0] NullLink = 11'd1024;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_SOLVE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  // Address of the node count register.
  localparam logic [1:0] ADDR_NODE_COUNT = 2'd0;

  // Result of one node, handed to the output stage.
  typedef struct packed {
    logic [NodeBits-1:0]  node;
    logic [DistBits-1:0]  distance;
    logic [CountBits-1:0] predecessor;
    logic                 negative_cycle;
    logic                 edges_lost;
    logic                 last;
  } spfa_result_t;

  // Saturating signed add of a distance and a weight.
  function automatic logic [DistBits-1:0] sat_add(input logic [DistBits-1:0] d,
                                                   input logic [WeightBits-1:0] w);
    logic [DistBits:0] s;
    begin
      s = {d[DistBits-1], d} + {{(DistBits-WeightBits+1){w[WeightBits-1]}}, w};
      if (s[DistBits] != s[DistBits-1])
        sat_add = s[DistBits] ? {1'b1, {(DistBits-1){1'b0}}} : {1'b0, {(DistBits-1){1'b1}}};
      else
        sat_add = s[DistBits-1:0];
    end
  endfunction
endpackage
`default_nettype wire

### hdl/spfa_shortest_paths.sv
// Top level of the SPFA shortest paths block.
// Usage: items arrive on in_* (func 0 add edge, 1 solve, 2 clear). Each item
// is one transaction; node_count is written on cfg_* at address 0.
// An add edge reads the list tail, then appends the edge in the edge memory.
// A clear sweeps the per-node list head and tail memories.
// A solve initializes the distances and lets the work ring settle, then pops
// nodes and examines each edge of a popped node (edge read, target read,
// then compare and write back), until it finds the ring empty or detects a
// negative cycle; it then emits one result per node and waits through the
// receiver's stalls.
// Results of a solve leave on out_* as n transactions, node 0 first, with
// tlast on the final node. in_tready is low until the item is finished.
// Reset clears the lists in a sweep during which no item is taken;
// node_count returns to 64. When the receiver stalls, the solver holds the
// pending result and waits; nothing is lost.
`default_nettype none
module spfa_shortest_paths
  import spfa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // func, from_node, to_node, weight, source_node
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // node, distance, predecessor, negative_cycle, edges_lost
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic [CountBits-1:0] node_count_r;
  logic                 idle, room, push;
  spfa_result_t         res, odata;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_NODE_COUNT) ? {25'd0, node_count_r} : 32'd0;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) node_count_r <= 7'd64;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_NODE_COUNT)
      node_count_r <= cfg_pwdata[6:0];
  end

  assign in_tready = idle;

  spfa_solver u_solver (
    .clk(clk), .rst_n(rst_n), .node_count(node_count_r),
    .in_fire(in_tvalid && in_tready),
    .func(in_tdata[1:0]), .from_node(in_tdata[7:2]), .to_node(in_tdata[13:8]),
    .weight(in_tdata[29:14]), .source_node(in_tdata[35:30]),
    .idle(idle), .res_room(room), .res_push(push), .res_data(res)
  );

  spfa_out_stage u_out (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(res), .has_room(room),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_data(odata)
  );

  assign out_tdata = {1'b0, odata.edges_lost, odata.negative_cycle,
                      odata.predecessor, odata.distance, odata.node};
  assign out_tlast = odata.last;
endmodule
`default_nettype wire

### hdl/spfa_out_stage.sv
// Two-entry output buffer that decouples the solver from the result receiver.
`default_nettype none
module spfa_out_stage
  import spfa_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire spfa_result_t push_data,
  output logic              has_room,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output spfa_result_t      out_data
);
  spfa_result_t buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       pop;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_data   = buf_r[rd_r];
  assign has_room   = (cnt_r == 2'd0);

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  // Buffer pointers and payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (pop) rd_r <= ~rd_r;
      if (push) wr_r <= ~wr_r;
    end
    if (push) buf_r[wr_r] <= push_data;
  end
endmodule
`default_nettype wire

### hdl/spfa_solver.sv
// Sequencer that loads edges, clears the graph and runs SPFA over the memories.
`default_nettype none
module spfa_solver
  import spfa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [CountBits-1:0]  node_count,
  input  wire logic                  in_fire,
  input  wire logic [1:0]            func,
  input  wire logic [NodeBits-1:0]   from_node,
  input  wire logic [NodeBits-1:0]   to_node,
  input  wire logic [WeightBits-1:0] weight,
  input  wire logic [NodeBits-1:0]   source_node,
  output logic                       idle,
  input  wire logic                  res_room,
  output logic                       res_push,
  output spfa_result_t               res_data
);
`include "spfa_shortest_paths_defines.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_POP   = 4'd2;
  localparam logic [3:0] S_HEAD  = 4'd3;
  localparam logic [3:0] S_EDGE  = 4'd4;
  localparam logic [3:0] S_TGT   = 4'd5;
  localparam logic [3:0] S_RELAX = 4'd6;
  localparam logic [3:0] S_ORD   = 4'd7;
  localparam logic [3:0] S_OWAIT = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_CLEAR = 4'd10;
  localparam logic [3:0] S_TAIL  = 4'd11;
  localparam logic [3:0] S_PEEK  = 4'd12;
  localparam logic [3:0] S_TREAD = 4'd13;

  // Edge store memories.
  logic [NodeBits-1:0]   etgt_mem [MaxEdges];
  logic [WeightBits-1:0] elen_mem [MaxEdges];
  logic [LinkBits-1:0]   elink_mem [MaxEdges];
  // Per-node memories.
  logic [LinkBits-1:0]   head_mem [MaxNodes];
  logic [LinkBits-1:0]   tail_mem [MaxNodes];
  logic [DistBits-1:0]   dist_mem [MaxNodes];
  logic [CountBits-1:0]  pred_mem [MaxNodes];
  logic [CountBits-1:0]  cnt_mem  [MaxNodes];
  logic [NodeBits-1:0]   ring_mem [MaxNodes];
  logic [MaxNodes-1:0]   queued_r;

  logic [3:0]            state_r;
  logic [CountBits-1:0]  n_r;
  logic [LinkBits-1:0]   edges_r;
  logic                  lost_r, neg_r;
  logic [NodeBits-1:0]   idx_r, v_r, src_r, from_r, to_r;
  logic [WeightBits-1:0] w_r;
  logic [LinkBits-1:0]   e_r;
  logic [DistBits-1:0]   dv_r;
  logic [NodeBits-1:0]   rd_ptr_r, wr_ptr_r;
  logic [CountBits-1:0]  fill_r;

  // Registered read data.
  logic [LinkBits-1:0]   head_q, tail_q, link_q;
  logic [NodeBits-1:0]   tgt_q, ring_q;
  logic [WeightBits-1:0] len_q;
  logic [DistBits-1:0]   dist_q, dtgt_q;
  logic [CountBits-1:0]  pred_q, cnt_q;
  logic [NodeBits-1:0]   da_sel, db_sel;

  logic [CountBits-1:0]  n_eff;
  logic [DistBits-1:0]   cand;
  logic [CountBits-1:0]  cnt_inc;

  always_comb begin
    if (node_count == '0) n_eff = 7'd1;
    else if (node_count > 7'd64) n_eff = 7'd64;
    else n_eff = node_count;
  end

  assign idle    = (state_r == S_IDLE);
  assign cand    = sat_add(dv_r, len_q);
  assign cnt_inc = cnt_q + 7'd1;

  // Read address of the distance ports, chosen by state.
  always_comb begin
    da_sel = v_r;
    db_sel = tgt_q;
    if (state_r == S_ORD || state_r == S_OWAIT || state_r == S_OUT) da_sel = idx_r;
  end

  // Memory reads, registered.
  always_ff @(posedge clk) begin
    head_q <= head_mem[(state_r == S_IDLE) ? from_node : v_r];
    tail_q <= tail_mem[(state_r == S_IDLE) ? from_node : from_r];
    link_q <= elink_mem[e_r[EdgeBits-1:0]];
    tgt_q  <= etgt_mem[e_r[EdgeBits-1:0]];
    len_q  <= elen_mem[e_r[EdgeBits-1:0]];
    ring_q <= ring_mem[rd_ptr_r];
    dist_q <= dist_mem[da_sel];
    dtgt_q <= dist_mem[db_sel];
    pred_q <= pred_mem[idx_r];
    cnt_q  <= cnt_mem[db_sel];
  end

  always_comb begin
    res_push          = (state_r == S_OUT) && res_room;
    res_data.node           = idx_r;
    res_data.distance       = dist_q;
    res_data.predecessor    = pred_q;
    res_data.negative_cycle = neg_r;
    res_data.edges_lost     = lost_r;
    res_data.last           = ({1'b0, idx_r} + 7'd1 == n_r);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      idx_r    <= '0;
      edges_r  <= '0;
      lost_r   <= 1'b0;
      neg_r    <= 1'b0;
      queued_r <= '0;
      fill_r   <= '0;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            n_r <= n_eff;
            if (func == FUNC_ADD) begin
              if (edges_r[EdgeBits] || {1'b0, from_node} >= n_eff ||
                  {1'b0, to_node} >= n_eff) begin
                lost_r <= 1'b1;
              end else begin
                from_r  <= from_node;
                to_r    <= to_node;
                w_r     <= weight;
                state_r <= S_TAIL;
              end
            end else if (func == FUNC_SOLVE) begin
              src_r   <= source_node;
              idx_r   <= '0;
              neg_r   <= 1'b0;
              state_r <= S_INIT;
            end else if (func == FUNC_CLEAR) begin
              idx_r   <= '0;
              edges_r <= '0;
              lost_r  <= 1'b0;
              state_r <= S_CLEAR;
            end
          end
        end
        S_TAIL: begin
          // tail_q valid now; append the edge.
          etgt_mem[edges_r[EdgeBits-1:0]]  <= to_r;
          elen_mem[edges_r[EdgeBits-1:0]]  <= w_r;
          elink_mem[edges_r[EdgeBits-1:0]] <= NullLink;
          if (tail_q != NullLink) elink_mem[tail_q[EdgeBits-1:0]] <= edges_r;
          else head_mem[from_r] <= edges_r;
          tail_mem[from_r] <= edges_r;
          edges_r <= edges_r + 11'd1;
          state_r <= S_IDLE;
        end
        S_CLEAR: begin
          head_mem[idx_r] <= NullLink;
          tail_mem[idx_r] <= NullLink;
          idx_r <= idx_r + 6'd1;
          if (idx_r == 6'(MaxNodes - 1)) state_r <= S_IDLE;
        end
        S_INIT: begin
          dist_mem[idx_r] <= (idx_r == src_r) ? '0 : InfDist;
          pred_mem[idx_r] <= '1;
          cnt_mem[idx_r]  <= 7'd0;
          idx_r <= idx_r + 6'd1;
          if (idx_r == 6'(MaxNodes - 1)) begin
            rd_ptr_r <= '0;
            if ({1'b0, src_r} < n_r) begin
              ring_mem[0] <= src_r;
              wr_ptr_r <= 6'd1;
              fill_r   <= 7'd1;
              queued_r <= MaxNodes'(1) << src_r;
            end else begin
              wr_ptr_r <= '0;
              fill_r   <= '0;
              queued_r <= '0;
            end
            state_r <= S_PEEK;
          end
        end
        S_PEEK: begin
          // Let the ring read see the entry written last cycle.
          state_r <= S_POP;
        end
        S_POP: begin
          if (fill_r == '0) begin
            idx_r   <= '0;
            state_r <= S_ORD;
          end else begin
            v_r      <= ring_q;
            rd_ptr_r <= rd_ptr_r + 6'd1;
            fill_r   <= fill_r - 7'd1;
            queued_r[ring_q] <= 1'b0;
            state_r  <= S_HEAD;
          end
        end
        S_HEAD: begin
          // head_q and dist_q of v arrive next cycle.
          state_r <= S_EDGE;
        end
        S_EDGE: begin
          dv_r    <= dist_q;
          e_r     <= head_q;
          state_r <= (head_q == NullLink) ? S_POP : S_TGT;
        end
        S_TGT: begin
          // Edge fields read; target distance read next.
          state_r <= S_TREAD;
        end
        S_TREAD: begin
          // Target distance and push count arrive next cycle.
          state_r <= S_RELAX;
        end
        S_RELAX: begin
          if ({1'b0, tgt_q} < n_r && $signed(cand) < $signed(dtgt_q)) begin
            dist_mem[tgt_q] <= cand;
            pred_mem[tgt_q] <= {1'b0, v_r};
            // A self loop changes the distance of the node being expanded.
            if (tgt_q == v_r) dv_r <= cand;
            if (!queued_r[tgt_q]) begin
              ring_mem[wr_ptr_r] <= tgt_q;
              wr_ptr_r <= wr_ptr_r + 6'd1;
              fill_r   <= fill_r + 7'd1;
              queued_r[tgt_q] <= 1'b1;
              cnt_mem[tgt_q]  <= cnt_inc;
              if (cnt_inc > n_r) neg_r <= 1'b1;
            end
          end
          e_r <= link_q;
          if ({1'b0, tgt_q} < n_r && $signed(cand) < $signed(dtgt_q) &&
              !queued_r[tgt_q] && cnt_inc > n_r) begin
            idx_r   <= '0;
            state_r <= S_ORD;
          end else if (link_q == NullLink) begin
            state_r <= S_PEEK;
          end else begin
            state_r <= S_TGT;
          end
        end
        S_ORD: state_r <= S_OWAIT;
        S_OWAIT: state_r <= S_OUT;
        S_OUT: begin
          if (res_room) begin
            if (res_data.last) state_r <= S_IDLE;
            else begin
              idx_r   <= idx_r + 6'd1;
              state_r <= S_ORD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SPFA_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= 7'd64, "ring overfilled")
  `SPFA_ASSERT_IMP(a_push_out, clk, rst_n, res_push, state_r == S_OUT, "result outside output")
  `SPFA_ASSERT_NXT(a_add_done, clk, rst_n, state_r == S_TAIL, state_r == S_IDLE, "add stuck")
endmodule
`default_nettype wire

### bench/spfa_shortest_paths_checker.sv
// Checker for the SPFA shortest paths block: tracks the graph, predicts and compares results.
module spfa_shortest_paths_checker
  import spfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          solves_seen,
  output int          neg_cycles_seen
);

  // Shadow copy of the graph and the node count register.
  logic [6:0]  node_reg;
  int          edge_to [MaxEdges];
  longint      edge_len [MaxEdges];
  int          edge_next [MaxEdges];
  int          head [MaxNodes];
  int          tail [MaxNodes];
  int          edge_total;
  bit          dropped;
  spfa_result_t shortest_q[$];

  function automatic int active_nodes();
    if (node_reg < 1) return 1;
    if (node_reg > MaxNodes) return MaxNodes;
    return node_reg;
  endfunction

  function automatic void wipe_graph();
    for (int i = 0; i < MaxNodes; i++) begin
      head[i] = MaxEdges;
      tail[i] = MaxEdges;
    end
    edge_total = 0;
    dropped = 0;
  endfunction

  function automatic void append_edge(int a, int b, logic [15:0] w);
    int n;
    n = active_nodes();
    if (edge_total >= MaxEdges || a >= n || b >= n) begin
      dropped = 1;
      return;
    end
    edge_to[edge_total] = b;
    edge_len[edge_total] = longint'($signed(w));
    edge_next[edge_total] = MaxEdges;
    if (tail[a] < MaxEdges) edge_next[tail[a]] = edge_total;
    else head[a] = edge_total;
    tail[a] = edge_total;
    edge_total++;
  endfunction

  // Queue-based relaxation from src, then one expected result per node.
  function automatic void predict_paths(int src);
    longint       best [MaxNodes];
    int           pred [MaxNodes];
    bit           queued [MaxNodes];
    int           pushes [MaxNodes];
    int           work[$];
    int           n, v, e, t;
    longint       cand;
    bit           neg;
    spfa_result_t r;
    n = active_nodes();
    neg = 0;
    for (int i = 0; i < MaxNodes; i++) begin
      best[i] = 1000000000;
      pred[i] = -1;
      queued[i] = 0;
      pushes[i] = 0;
    end
    if (src < n) begin
      best[src] = 0;
      work = {work, src};
      queued[src] = 1;
    end
    while (work.size() > 0 && !neg) begin
      v = work.pop_front();
      queued[v] = 0;
      e = head[v];
      while (e < MaxEdges && !neg) begin
        t = edge_to[e];
        if (t < n) begin
          cand = best[v] + edge_len[e];
          if (cand > 64'sd2147483647) cand = 64'sd2147483647;
          if (cand < -64'sd2147483648) cand = -64'sd2147483648;
          if (cand < best[t]) begin
            best[t] = cand;
            pred[t] = v;
            if (!queued[t]) begin
              work = {work, t};
              queued[t] = 1;
              pushes[t]++;
              if (pushes[t] > n) neg = 1;
            end
          end
        end
        e = edge_next[e];
      end
    end
    if (neg) neg_cycles_seen++;
    for (int k = 0; k < n; k++) begin
      r.node = k[5:0];
      r.distance = best[k][31:0];
      r.predecessor = pred[k][6:0];
      r.negative_cycle = neg;
      r.edges_lost = dropped;
      r.last = (k == n - 1);
      shortest_q = {shortest_q, r};
    end
  endfunction

  // Watch configuration writes, accepted items and results.
  always @(posedge clk) begin
    logic [47:0]  want, got;
    spfa_result_t exp_r;
    if (!rst_n) begin
      node_reg = 7'd64;
      wipe_graph();
      shortest_q.delete();
      fail_count = 0;
      results_seen = 0;
      solves_seen = 0;
      neg_cycles_seen = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == ADDR_NODE_COUNT)
        node_reg = cfg_pwdata[6:0];
      if (in_tvalid && in_tready) begin
        case (in_tdata[1:0])
          FUNC_ADD:   append_edge(in_tdata[7:2], in_tdata[13:8], in_tdata[29:14]);
          FUNC_CLEAR: wipe_graph();
          FUNC_SOLVE: begin
            solves_seen++;
            predict_paths(in_tdata[35:30]);
          end
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (shortest_q.size() == 0) begin
          $error("result transaction with nothing expected: tdata=%h", out_tdata);
          fail_count++;
        end else begin
          exp_r = shortest_q.pop_front();
          want = {1'b0, exp_r.edges_lost, exp_r.negative_cycle, exp_r.predecessor,
                  exp_r.distance, exp_r.node};
          got = out_tdata;
          if (want[5:0] != got[5:0]) begin
            $error("node: expected %0d, got %0d", want[5:0], got[5:0]);
            fail_count++;
          end
          if (want[37:6] != got[37:6]) begin
            $error("distance: expected %0d, got %0d", $signed(want[37:6]),
                   $signed(got[37:6]));
            fail_count++;
          end
          if (want[44:38] != got[44:38]) begin
            $error("predecessor: expected %h, got %h", want[44:38], got[44:38]);
            fail_count++;
          end
          if (want[45] != got[45]) begin
            $error("negative_cycle: expected %b, got %b", want[45], got[45]);
            fail_count++;
          end
          if (want[46] != got[46]) begin
            $error("edges_lost: expected %b, got %b", want[46], got[46]);
            fail_count++;
          end
          if (exp_r.last != out_tlast) begin
            $error("last: expected %b, got %b", exp_r.last, out_tlast);
            fail_count++;
          end
        end
      end
    end
    pending = shortest_q.size();
  end

endmodule

### bench/spfa_shortest_paths_tb.sv
// Top of the SPFA shortest paths testbench: clock, reset, stimulus and verdict.
module spfa_shortest_paths_tb;
  import spfa_pkg::*;

  localparam int CycleLimit = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // func, from_node, to_node, weight, source_node
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // node, distance, predecessor, negative_cycle, edges_lost
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending, results_seen, solves_seen, neg_cycles_seen;
  int          cycles;
  bit          quiet;
  int          stall_left;
  int          nodes;

  spfa_shortest_paths DUT (.*);

  spfa_shortest_paths_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: random stall bursts unless the run is in its quiet stretch.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Present one item and hold it until the block takes the transaction.
  task automatic send_item(logic [1:0] f, int a, int b, logic [15:0] w, int s);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, s[5:0], w, b[5:0], a[5:0], f};
    do @(posedge clk); while (!in_tready);
  endtask

  // Wait until every expected result is back and the block has settled.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_nodes(int value);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_NODE_COUNT;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    nodes = (value < 1) ? 1 : (value > MaxNodes) ? MaxNodes : value;
  endtask

  // One random graph: a clear, mostly valid edges, a few out of range, then a solve.
  task automatic random_graph(bit want_negative);
    int k;
    int a, b;
    logic [15:0] w;
    send_item(FUNC_CLEAR, $urandom, $urandom, 16'($urandom), $urandom);
    k = $urandom_range(3, 20);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom_range(0, 63);
        b = $urandom_range(0, 63);
      end else begin
        a = $urandom_range(0, nodes - 1);
        b = $urandom_range(0, nodes - 1);
      end
      if ($urandom_range(0, 7) == 0) w = 16'($urandom);
      else if (want_negative) w = 16'($signed($urandom_range(0, 40)) - 20);
      else w = 16'($urandom_range(0, 60));
      send_item(FUNC_ADD, a, b, w, $urandom);
    end
    if ($urandom_range(0, 9) == 0)
      send_item(FUNC_NOP, $urandom, $urandom, 16'($urandom), $urandom);
    send_item(FUNC_SOLVE, $urandom, $urandom, 16'($urandom),
              ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                          : $urandom_range(0, nodes - 1));
  endtask

  initial begin
    rst_n = 1'b0;
    quiet = 1'b0;
    cycles = 0;
    nodes = MaxNodes;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = ADDR_NODE_COUNT;
    cfg_pwdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty graph, weight extremes, corner nodes, unused code.
    send_item(FUNC_SOLVE, 0, 0, 0, 0);
    send_item(FUNC_ADD, 0, 63, 16'h7fff, 0);
    send_item(FUNC_ADD, 63, 1, 16'h8000, 0);
    send_item(FUNC_ADD, 0, 1, 16'hffff, 0);
    send_item(FUNC_ADD, 0, 1, 16'hffff, 0);
    send_item(FUNC_NOP, 63, 63, 16'hffff, 63);
    send_item(FUNC_SOLVE, 0, 0, 0, 0);
    send_item(FUNC_SOLVE, 0, 0, 0, 63);
    // A two-node negative loop.
    send_item(FUNC_ADD, 1, 2, 16'hfffe, 0);
    send_item(FUNC_ADD, 2, 1, 16'h0001, 0);
    send_item(FUNC_SOLVE, 0, 0, 0, 0);
    send_item(FUNC_CLEAR, 0, 0, 0, 0);
    send_item(FUNC_SOLVE, 0, 0, 0, 5);

    // Single node, out-of-range edges and source.
    write_nodes(1);
    send_item(FUNC_ADD, 0, 0, 16'd5, 0);
    send_item(FUNC_ADD, 0, 1, 16'd5, 0);
    send_item(FUNC_SOLVE, 0, 0, 0, 0);
    send_item(FUNC_SOLVE, 0, 0, 0, 1);
    write_nodes(0);
    send_item(FUNC_SOLVE, 0, 0, 0, 0);

    // Load with many nodes, then shrink so some targets fall out of range.
    write_nodes(127);
    send_item(FUNC_CLEAR, 0, 0, 0, 0);
    send_item(FUNC_ADD, 0, 40, 16'd3, 0);
    send_item(FUNC_ADD, 0, 2, 16'd9, 0);
    send_item(FUNC_ADD, 40, 2, 16'd1, 0);
    write_nodes(6);
    send_item(FUNC_SOLVE, 0, 0, 0, 0);

    // Random graphs across several node counts.
    for (int g = 0; g < 14; g++) begin
      if (g % 3 == 0) write_nodes($urandom_range(2, 10));
      if (g == 7) drain();
      random_graph($urandom_range(0, 2) == 0);
    end
    write_nodes(64);
    random_graph(1'b0);

    // Final stretch without idling on either side.
    write_nodes(8);
    quiet = 1'b1;
    for (int g = 0; g < 3; g++) random_graph(g == 1);

    drain();
    $display("Covered %0d solves (%0d on negative cycles) and %0d result transactions,",
             solves_seen, neg_cycles_seen, results_seen);
    $display("node counts from 1 to 64, dropped edges and out-of-range nodes and sources.");
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
